>>> rtl/irat_pkg.sv
`default_nettype none
package irat_pkg;
	localparam int MAX_RANGES_DEF = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int OP_W = 3;
	localparam int ST_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_RELEASE = 3'd1,
		OP_CHECK = 3'd2,
		OP_LIST = 3'd3,
		OP_LISTM = 3'd4
	} op_t;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CUT_RD,
		S_CUT,
		S_CUT_DONE,
		S_COPY_RD,
		S_COPY,
		S_CHK_RD,
		S_CHK,
		S_LIST_RD,
		S_LIST,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic cut_start;
		logic cut_step;
		logic copy_start;
		logic copy_step;
		logic commit;
		logic rd_start;
		logic rd_step;
		logic emit_list;
		logic emit_flush;
		logic emit_resp;
		logic [ST_W-1:0] resp_status;
	} irat_cmd_t;

	typedef struct packed {
		logic invalid;
		logic cut_end;
		logic ovf;
		logic copy_end;
		logic rd_end;
		logic empty;
		logic out_free;
	} irat_sts_t;
endpackage
`default_nettype wire

>>> rtl/irat_if.sv
`default_nettype none
interface irat_in_if
	import irat_pkg::*;
#(parameter int COORD_BITS = COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic signed [COORD_BITS-1:0] range_start;
	logic signed [COORD_BITS-1:0] range_end;
	modport source (output valid, operation, range_start, range_end, input ready);
	modport sink (input valid, operation, range_start, range_end, output ready);
endinterface

interface irat_out_if
	import irat_pkg::*;
#(parameter int COORD_BITS = COORD_BITS_DEF);
	logic valid;
	logic ready;
	logic [ST_W-1:0] status;
	logic available;
	logic has_range;
	logic signed [COORD_BITS-1:0] out_start;
	logic signed [COORD_BITS-1:0] out_end;
	logic last;
	modport source (output valid, status, available, has_range, out_start, out_end, last,
		input ready);
	modport sink (input valid, status, available, has_range, out_start, out_end, last,
		output ready);
endinterface
`default_nettype wire

>>> rtl/irat_ctrl.sv
`default_nettype none
module irat_ctrl
	import irat_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [OP_W-1:0] in_op,
	input wire irat_sts_t sts,
	output irat_cmd_t cmd
);
	state_t state_q, state_nx;
	logic [OP_W-1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
		end else begin
			state_q <= state_nx;
			if (in_valid && in_ready) op_q <= in_op;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nx = S_RESP;
			S_RESP: begin
				if (sts.invalid && op_q <= OP_CHECK) begin
					if (sts.out_free) state_nx = S_IDLE;
				end else if (op_q == OP_ALLOC || op_q == OP_RELEASE) begin
					state_nx = S_CUT_RD;
				end else if (op_q == OP_CHECK) begin
					state_nx = S_CHK_RD;
				end else if (op_q == OP_LIST || op_q == OP_LISTM) begin
					state_nx = S_LIST_RD;
				end else if (sts.out_free) begin
					state_nx = S_IDLE;
				end
			end
			S_CUT_RD: state_nx = sts.rd_end ? S_CUT_DONE : S_CUT;
			S_CUT: if (sts.cut_end) state_nx = S_CUT_DONE;
			S_CUT_DONE: begin
				if (sts.ovf) begin
					if (sts.out_free) state_nx = S_IDLE;
				end else state_nx = S_COPY_RD;
			end
			S_COPY_RD: state_nx = S_COPY;
			S_COPY: if (sts.copy_end && sts.out_free) state_nx = S_IDLE;
			S_CHK_RD: state_nx = sts.rd_end ? S_LIST : S_CHK;
			S_CHK: if (sts.rd_end) state_nx = S_LIST;
			S_LIST_RD: state_nx = sts.empty ? S_LIST : S_LIST;
			S_LIST: if (sts.out_free && sts.rd_end) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.resp_status = ST_OK;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_RESP: begin
				if (sts.invalid && op_q <= OP_CHECK) begin
					cmd.emit_resp = sts.out_free;
					cmd.resp_status = ST_INVALID;
				end else if (op_q <= OP_LISTM) begin
					cmd.rd_start = 1'b1;
					cmd.cut_start = 1'b1;
				end else begin
					cmd.emit_resp = sts.out_free;
				end
			end
			S_CUT_RD: begin
				cmd.rd_step = 1'b1;
				cmd.cut_step = 1'b0;
			end
			S_CUT: cmd.cut_step = 1'b1;
			S_CUT_DONE: begin
				if (sts.ovf) begin
					cmd.emit_resp = sts.out_free;
					cmd.resp_status = ST_FULL;
				end else begin
					cmd.copy_start = 1'b1;
				end
			end
			S_COPY_RD: cmd.copy_step = 1'b1;
			S_COPY: begin
				cmd.copy_step = !sts.copy_end;
				if (sts.copy_end) begin
					cmd.emit_resp = sts.out_free;
					cmd.commit = sts.out_free;
				end
			end
			S_CHK_RD, S_CHK: cmd.rd_step = 1'b1;
			S_LIST_RD: cmd.rd_step = 1'b0;
			S_LIST: begin
				cmd.emit_list = sts.out_free;
				cmd.emit_flush = sts.out_free && sts.rd_end;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/irat_dp.sv
`default_nettype none
module irat_dp
	import irat_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [OP_W-1:0] in_op,
	input wire logic signed [COORD_BITS-1:0] in_start,
	input wire logic signed [COORD_BITS-1:0] in_end,
	input wire irat_cmd_t cmd,
	output irat_sts_t sts,
	output logic out_valid,
	input wire logic out_ready,
	output logic [ST_W-1:0] out_status,
	output logic out_available,
	output logic out_has_range,
	output logic signed [COORD_BITS-1:0] out_start,
	output logic signed [COORD_BITS-1:0] out_end,
	output logic out_last
);
	localparam int IW = $clog2(MAX_RANGES + 1);
	localparam int SW = $clog2(MAX_RANGES + 3);
	localparam int XI = $clog2(MAX_RANGES);
	localparam int XS = $clog2(MAX_RANGES + 2);

	logic signed [COORD_BITS-1:0] tlo_q [MAX_RANGES];
	logic signed [COORD_BITS-1:0] thi_q [MAX_RANGES];
	logic signed [COORD_BITS-1:0] slo_q [MAX_RANGES+2];
	logic signed [COORD_BITS-1:0] shi_q [MAX_RANGES+2];
	logic [IW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [SW-1:0] n_q;
	logic [SW-1:0] wi_q;
	logic ins_done_q;
	logic [OP_W-1:0] op_q;
	logic signed [COORD_BITS-1:0] s_q, e_q, clo_q, chi_q;
	logic have_q, avail_q, flushed_q;

	logic signed [COORD_BITS-1:0] rlo, rhi;
	logic ov;
	assign rlo = tlo_q[idx_q[XI-1:0]];
	assign rhi = thi_q[idx_q[XI-1:0]];
	assign ov = !(rhi <= s_q || rlo >= e_q);

	always_comb begin
		sts.invalid = !(s_q < e_q);
		sts.rd_end = (idx_q >= count_q);
		sts.cut_end = (idx_q + 1'b1 >= {1'b0, count_q}) || (idx_q >= count_q);
		sts.ovf = (op_q == OP_ALLOC) ? (n_q + 1'b1 > SW'(MAX_RANGES))
			: (n_q > SW'(MAX_RANGES));
		sts.copy_end = (wi_q >= n_q + SW'(op_q == OP_ALLOC));
		sts.empty = (count_q == '0);
		sts.out_free = !out_valid || out_ready;
	end

	logic [SW-1:0] n_nx;
	always_comb begin
		n_nx = n_q;
		if (!ov) n_nx = n_q + 1'b1;
		else n_nx = n_q + SW'(rlo < s_q) + SW'(rhi > e_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			s_q <= in_start;
			e_q <= in_end;
		end
		if (cmd.cut_start) n_q <= '0;
		if ((cmd.cut_step || (cmd.rd_step && (op_q <= OP_RELEASE))) && idx_q < count_q) begin
			if (!ov) begin
				if (n_q < SW'(MAX_RANGES + 2)) begin
					slo_q[n_q[XS-1:0]] <= rlo;
					shi_q[n_q[XS-1:0]] <= rhi;
				end
			end else begin
				if (rlo < s_q && n_q < SW'(MAX_RANGES + 2)) begin
					slo_q[n_q[XS-1:0]] <= rlo;
					shi_q[n_q[XS-1:0]] <= s_q;
				end
				if (rhi > e_q && (n_q + SW'(rlo < s_q)) < SW'(MAX_RANGES + 2)) begin
					slo_q[XS'(n_q + SW'(rlo < s_q))] <= e_q;
					shi_q[XS'(n_q + SW'(rlo < s_q))] <= rhi;
				end
			end
			n_q <= n_nx;
		end
		if (cmd.copy_start) begin
			wi_q <= '0;
			ins_done_q <= (op_q != OP_ALLOC);
			idx_q <= '0;
		end else if (cmd.rd_start) begin
			idx_q <= '0;
			avail_q <= 1'b1;
			have_q <= 1'b0;
			flushed_q <= 1'b0;
		end
		if (cmd.emit_flush && op_q == OP_LISTM) flushed_q <= 1'b1;
		if (cmd.copy_step && !sts.copy_end) begin
			if (!ins_done_q && (wi_q[IW-1:0] == idx_q[IW-1:0]) &&
				(IW'(wi_q) >= IW'(n_q) || !(slo_q[XS'(idx_q)] < s_q))) begin
				tlo_q[wi_q[XI-1:0]] <= s_q;
				thi_q[wi_q[XI-1:0]] <= e_q;
				ins_done_q <= 1'b1;
			end else begin
				tlo_q[wi_q[XI-1:0]] <= slo_q[XS'(idx_q)];
				thi_q[wi_q[XI-1:0]] <= shi_q[XS'(idx_q)];
				idx_q <= idx_q + 1'b1;
			end
			wi_q <= wi_q + 1'b1;
		end
		if ((cmd.cut_step || cmd.rd_step) && idx_q < count_q) begin
			idx_q <= idx_q + 1'b1;
			if (ov) avail_q <= 1'b0;
		end
		if (cmd.emit_list && op_q >= OP_LIST && idx_q < count_q) begin
			idx_q <= idx_q + 1'b1;
			if (op_q == OP_LIST || !have_q) begin
				clo_q <= rlo;
				chi_q <= rhi;
			end else if (chi_q >= rlo) begin
				if (rhi > chi_q) chi_q <= rhi;
			end else begin
				clo_q <= rlo;
				chi_q <= rhi;
			end
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.commit) count_q <= IW'(n_q + SW'(op_q == OP_ALLOC));
	end

	logic list_out, merged_out;
	assign merged_out = have_q && idx_q < count_q && !(chi_q >= rlo);
	assign list_out = cmd.emit_list && (
		(op_q == OP_LIST && idx_q < count_q) ||
		(op_q == OP_LISTM && (merged_out || (idx_q >= count_q && !flushed_q))) ||
		(op_q == OP_CHECK) || (count_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit_resp || list_out) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_resp) begin
			out_status <= cmd.resp_status;
			out_available <= 1'b0;
			out_has_range <= 1'b0;
			out_start <= '0;
			out_end <= '0;
			out_last <= 1'b1;
		end else if (list_out) begin
			out_status <= ST_OK;
			out_available <= (op_q == OP_CHECK) && avail_q;
			if (op_q == OP_CHECK || count_q == '0) begin
				out_has_range <= 1'b0;
				out_start <= '0;
				out_end <= '0;
				out_last <= 1'b1;
			end else if (op_q == OP_LIST) begin
				out_has_range <= 1'b1;
				out_start <= rlo;
				out_end <= rhi;
				out_last <= (idx_q + 1'b1 == count_q);
			end else begin
				out_has_range <= 1'b1;
				out_start <= clo_q;
				out_end <= chi_q;
				out_last <= (idx_q >= count_q);
			end
		end
	end

	// Merged list: the last-remembered span is emitted on the cycle it closes.
	// When the state machine sees rd_end it leaves after flushing.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= IW'(MAX_RANGES))
		else $error("entry count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.commit |-> !sts.ovf)
		else $error("commit on overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_resp && list_out) |-> 1'b0)
		else $error("two responses in one cycle");
endmodule
`default_nettype wire

>>> rtl/interval_range_allocation_table_core.sv
// Interval range table: keeps up to MAX_RANGES sorted half-open ranges in flip-flops and
// takes one operation word at a time; in.ready is high only while idle. Allocate and release
// make one scan pass into scratch and one copy pass back; check and both list operations
// make one scan pass. The table scan reads a single entry per cycle unless the output stalls.
// Results leave through a registered output word; list operations produce one word per
// entry or merged span, the final one carrying last, and a stalled output word holds the scan.
`default_nettype none
module interval_range_allocation_table_core
	import irat_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	irat_in_if.sink in,
	irat_out_if.source out
);
	irat_cmd_t cmd;
	irat_sts_t sts;

	irat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .in_op(in.operation),
		.sts(sts), .cmd(cmd)
	);

	irat_dp #(.MAX_RANGES(MAX_RANGES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_op(in.operation), .in_start(in.range_start), .in_end(in.range_end),
		.cmd(cmd), .sts(sts),
		.out_valid(out.valid), .out_ready(out.ready),
		.out_status(out.status), .out_available(out.available),
		.out_has_range(out.has_range), .out_start(out.out_start),
		.out_end(out.out_end), .out_last(out.last)
	);
endmodule
`default_nettype wire
